// ===== sv/bir_pkg.sv =====
// Shared types and constants for the bilinear image resizer.
`default_nettype none
package bir_pkg;

  localparam int unsigned PLANE_DEPTH = 16384;
  localparam int unsigned TAB_DEPTH   = 256;
  localparam logic [16:0] FRAC_ONE    = 17'h10000;

  typedef enum logic [1:0] {
    K_PIX = 2'd0,
    K_COL = 2'd1,
    K_ROW = 2'd2,
    K_REQ = 2'd3
  } kind_t;

  // entry layout: {pos_a, pos_b, frac}
  typedef struct packed {
    kind_t       kind;
    logic [13:0] pix_addr;
    logic [63:0] pix;
    logic [7:0]  ox;
    logic [7:0]  oy;
    logic [30:0] entry;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/bir_front.sv =====
// Front part: decodes incoming items and queues them for the back part.
`default_nettype none
module bir_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          func,
  input  wire logic [6:0]          src_x,
  input  wire logic [6:0]          src_y,
  input  wire logic signed [15:0]  ch0,
  input  wire logic signed [15:0]  ch1,
  input  wire logic signed [15:0]  ch2,
  input  wire logic signed [15:0]  ch3,
  input  wire logic [7:0]          out_x,
  input  wire logic [7:0]          out_y,
  input  wire logic [6:0]          pos_a,
  input  wire logic [6:0]          pos_b,
  input  wire logic [16:0]         frac,
  output bir_pkg::item_t           q_item,
  output logic                     q_valid,
  input  wire logic                q_pop
);

  bir_pkg::item_t item_c;
  bir_pkg::item_t qmem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  always_comb begin
    item_c.kind     = bir_pkg::kind_t'(func);
    item_c.pix_addr = {src_y, src_x};
    item_c.pix      = {ch3, ch2, ch1, ch0};
    item_c.ox       = out_x;
    item_c.oy       = out_y;
    item_c.entry    = {pos_a, pos_b,
                       (frac > bir_pkg::FRAC_ONE) ? bir_pkg::FRAC_ONE : frac};
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> count != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== sv/bir_back.sv =====
// Back part: source plane and tables, bilinear blend and result register.
`default_nettype none
module bir_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bir_pkg::item_t      q_item,
  input  wire logic                q_valid,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       res0,
  output logic signed [15:0]       res1,
  output logic signed [15:0]       res2,
  output logic signed [15:0]       res3
);

  typedef enum logic [1:0] {S_IDLE, S_PIX, S_MATH, S_OUT} state_t;

  state_t state;
  logic [2:0]  pcnt;
  logic [2:0]  ph;
  logic [1:0]  ch;

  logic [63:0] plane [bir_pkg::PLANE_DEPTH];
  logic [30:0] col_mem [bir_pkg::TAB_DEPTH];
  logic [30:0] row_mem [bir_pkg::TAB_DEPTH];
  logic [30:0] col_q;
  logic [30:0] row_q;
  logic [63:0] pix_q;
  logic [63:0] px [4];
  logic        rd_en;
  logic [13:0] rd_addr;
  logic [6:0]  rd_row;
  logic [6:0]  rd_col;

  logic [16:0] fx;
  logic [16:0] fy;
  logic signed [15:0] p00, p01, p10, p11;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod, h0, h1;
  logic signed [32:0] d;
  logic signed [51:0] acc, fin;
  logic signed [19:0] v;
  logic signed [15:0] sat;
  logic signed [15:0] res [4];
  logic [5:0] sel;

  assign q_pop = (state == S_IDLE) & q_valid;
  assign fx    = col_q[16:0];
  assign fy    = row_q[16:0];
  assign sel   = {ch, 4'b0};
  assign p00   = $signed(px[0][sel +: 16]);
  assign p01   = $signed(px[1][sel +: 16]);
  assign p10   = $signed(px[2][sel +: 16]);
  assign p11   = $signed(px[3][sel +: 16]);

  assign rd_en   = (state == S_PIX) && (pcnt < 3'd4);
  assign rd_row  = pcnt[1] ? row_q[23:17] : row_q[30:24];
  assign rd_col  = pcnt[0] ? col_q[23:17] : col_q[30:24];
  assign rd_addr = {rd_row, rd_col};

  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == bir_pkg::K_PIX) begin
      plane[q_item.pix_addr] <= q_item.pix;
    end
    if (rd_en) begin
      pix_q <= plane[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == bir_pkg::K_COL) begin
      col_mem[q_item.ox] <= q_item.entry;
    end
    if (q_pop && q_item.kind == bir_pkg::K_REQ) begin
      col_q <= col_mem[q_item.ox];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == bir_pkg::K_ROW) begin
      row_mem[q_item.oy] <= q_item.entry;
    end
    if (q_pop && q_item.kind == bir_pkg::K_REQ) begin
      row_q <= row_mem[q_item.oy];
    end
  end

  always_comb begin
    mul_a = $signed({p01[15], p01[15], p01}) - $signed({p00[15], p00[15], p00});
    mul_b = $signed({1'b0, fx});
    case (ph)
      3'd1: mul_a = $signed({p11[15], p11[15], p11}) - $signed({p10[15], p10[15], p10});
      3'd4: begin
        mul_a = $signed({{2{d[32]}}, d[32:17]});
        mul_b = $signed({1'b0, fy});
      end
      3'd5: begin
        mul_a = $signed({1'b0, d[16:0]});
        mul_b = $signed({1'b0, fy});
      end
      default: ;
    endcase
  end

  always_comb begin
    fin = acc + $signed({{16{prod[35]}}, prod});
    v   = fin[51:32];
    if (v > 20'sd32767) begin
      sat = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == S_PIX && pcnt != 3'd0) begin
      px[2'(pcnt - 3'd1)] <= pix_q;
    end
    if (state == S_MATH) begin
      case (ph)
        3'd1: h0 <= $signed({{4{p00[15]}}, p00, 16'b0}) + prod;
        3'd2: h1 <= $signed({{4{p10[15]}}, p10, 16'b0}) + prod;
        3'd3: d <= $signed(h1[32:0]) - $signed(h0[32:0]);
        3'd5: acc <= $signed({h0, 16'b0}) + $signed({prod[34:0], 17'b0})
                     + 52'sh80000000;
        3'd6: res[ch] <= sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pcnt      <= 3'd0;
      ph        <= 3'd0;
      ch        <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop && q_item.kind == bir_pkg::K_REQ) begin
            pcnt  <= 3'd0;
            state <= S_PIX;
          end
        end
        S_PIX: begin
          if (pcnt == 3'd4) begin
            ph    <= 3'd0;
            ch    <= 2'd0;
            state <= S_MATH;
          end else begin
            pcnt <= pcnt + 3'd1;
          end
        end
        S_MATH: begin
          if (ph == 3'd6) begin
            ph <= 3'd0;
            ch <= ch + 2'd1;
            if (ch == 2'd3) begin
              state <= S_OUT;
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            res0      <= res[0];
            res1      <= res[1];
            res2      <= res[2];
            res3      <= res[3];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result shown without a finished request");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MATH) |-> ph <= 3'd6)
    else $error("blend phase out of range");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX) |-> pcnt <= 3'd4)
    else $error("pixel fetch count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(res0) && $stable(res3))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== sv/bilinear_image_resize.sv =====
// Top level of the bilinear image resizer: front queue and back engine.
//
// Input channel in_valid/in_stall carries one item per handshake: a source
// pixel write, a column entry write, a row entry write or an output pixel
// request, chosen by func. Output channel out_valid/out_stall carries one
// result item of four Q8.8 channels for each request, in request order.
// A two-entry queue in front accepts items while the back engine works.
// Writes are applied as the back engine pops them. A request passes from
// acceptance to out_valid through the queue, a read of four source pixels
// from the single-ported plane memory, each channel in turn through the one
// shared 18x18 multiplier, and the output register. Writes flow at one per
// cycle while the engine is idle; no item leaves the queue until a request's
// result is loaded into the output register.
// Reset clears the queue, the sequencer and out_valid; memory contents are
// left as they are and must be written before they are read.
// While the receiver stalls the result holds; the engine finishes the next
// request and waits, and the queue fills and then stalls the sender.
`default_nettype none
module bilinear_image_resize (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          func,
  input  wire logic [6:0]          src_x,
  input  wire logic [6:0]          src_y,
  input  wire logic signed [15:0]  ch0,
  input  wire logic signed [15:0]  ch1,
  input  wire logic signed [15:0]  ch2,
  input  wire logic signed [15:0]  ch3,
  input  wire logic [7:0]          out_x,
  input  wire logic [7:0]          out_y,
  input  wire logic [6:0]          pos_a,
  input  wire logic [6:0]          pos_b,
  input  wire logic [16:0]         frac,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       res0,
  output logic signed [15:0]       res1,
  output logic signed [15:0]       res2,
  output logic signed [15:0]       res3
);

  bir_pkg::item_t q_item;
  logic q_valid;
  logic q_pop;

  bir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .src_x    (src_x),
    .src_y    (src_y),
    .ch0      (ch0),
    .ch1      (ch1),
    .ch2      (ch2),
    .ch3      (ch3),
    .out_x    (out_x),
    .out_y    (out_y),
    .pos_a    (pos_a),
    .pos_b    (pos_b),
    .frac     (frac),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  bir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res0      (res0),
    .res1      (res1),
    .res2      (res2),
    .res3      (res3)
  );

endmodule
`default_nettype wire
